[rtl/core/triangle_tangent_space_macros.svh]
// Assertion macros used by the tangent-space checker.
`ifndef TRIANGLE_TANGENT_SPACE_MACROS_SVH
`define TRIANGLE_TANGENT_SPACE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tangent space check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tangent space check failed");

`endif

[rtl/core/tts_pkg.sv]
// Shared constants for the triangle tangent-space block.
`default_nettype none
package tts_pkg;
    localparam int RES_W      = 16;   // Q2.14 result width
    localparam int UNIT_SHIFT = 14;   // 1.0 in Q2.14 is 1 << UNIT_SHIFT
    localparam int UNIT_ONE   = 16384;
    localparam int NORM_BITS  = 30;   // magnitude width before the length step
    localparam int SQ_W       = 64;   // sum of squares and square root width
    localparam int LEN_W      = 32;   // vector length width
    localparam int Q_W        = 15;   // quotient width, holds UNIT_ONE
endpackage
`default_nettype wire

[rtl/core/triangle_tangent_space.sv]
// Per-triangle unit tangent and bitangent from three corner requests.
// Corner requests one and two are only stored. The third corner runs a
// shared serial multiply-accumulate (14 products), then per vector a shift
// normalizer, three squares, a 32-step square root and three 15-step divides;
// no request is taken meanwhile. Reset clears the pending corner count,
// the mode bit and the output valid.
`default_nettype none
module triangle_tangent_space #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wr_en,
    input  wire                                 cfg_wr_data,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire signed [COORD_WIDTH-1:0]        pos_x,
    input  wire signed [COORD_WIDTH-1:0]        pos_y,
    input  wire signed [COORD_WIDTH-1:0]        pos_z,
    input  wire signed [COORD_WIDTH-1:0]        tex_u,
    input  wire signed [COORD_WIDTH-1:0]        tex_v,
    input  wire                                 end_of_mesh,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic signed [tts_pkg::RES_W-1:0]    tangent_x,
    output logic signed [tts_pkg::RES_W-1:0]    tangent_y,
    output logic signed [tts_pkg::RES_W-1:0]    tangent_z,
    output logic signed [tts_pkg::RES_W-1:0]    bitangent_x,
    output logic signed [tts_pkg::RES_W-1:0]    bitangent_y,
    output logic signed [tts_pkg::RES_W-1:0]    bitangent_z,
    output logic                                degenerate
);
    import tts_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int D     = CW + 1;
    localparam int AW    = 2 * CW + 3;
    localparam int BW    = (D > NORM_BITS) ? D : NORM_BITS;
    localparam int ACCW  = (AW > SQ_W) ? AW : SQ_W;
    localparam int DEN_W = LEN_W + UNIT_SHIFT;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL    = 4'd1;
    localparam logic [3:0] ST_NLOAD  = 4'd2;
    localparam logic [3:0] ST_NSHIFT = 4'd3;
    localparam logic [3:0] ST_SQ     = 4'd4;
    localparam logic [3:0] ST_SQRT   = 4'd5;
    localparam logic [3:0] ST_DLOAD  = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    localparam logic [3:0] LAST_TERM = 4'd13;
    localparam logic [3:0] LAST_SQ   = 4'd2;
    localparam logic [3:0] LAST_DIV  = 4'(Q_W - 1);

    function automatic logic [D-1:0] sx(input logic [CW-1:0] x);
        return {x[CW-1], x};
    endfunction

    function automatic logic [D-1:0] mag_d(input logic [D-1:0] x);
        return x[D-1] ? (~x + D'(1)) : x;
    endfunction

    logic [3:0]          state_reg;
    logic [1:0]          cnt_reg;
    logic                mirror_reg;
    logic [CW-1:0]       pos_reg [6];
    logic [CW-1:0]       tex_reg [4];
    logic [D-1:0]        du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic [D-1:0]        e1_reg [3];
    logic [D-1:0]        e2_reg [3];
    logic [3:0]          term_reg;
    logic                mul_busy_reg;
    logic [ACCW-1:0]     mcand_reg;
    logic [BW-1:0]       mplier_reg;
    logic                mneg_reg;
    logic [ACCW-1:0]     acc_reg;
    logic [AW-1:0]       det_reg;
    logic [AW-1:0]       tan_reg [3];
    logic [AW-1:0]       bt_reg [3];
    logic                vsel_reg;
    logic [1:0]          comp_reg;
    logic [AW-1:0]       nm_reg [3];
    logic                nneg_reg [3];
    logic [SQ_W-1:0]     root_reg;
    logic [SQ_W-1:0]     bit_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [Q_W-1:0]      q_reg;
    logic [3:0]          dcnt_reg;
    logic [RES_W-1:0]    rt_reg [3];
    logic [RES_W-1:0]    rb_reg [3];
    logic                degen_reg;
    logic                out_valid_reg;
    logic [RES_W-1:0]    out_t_reg [3];
    logic [RES_W-1:0]    out_b_reg [3];
    logic                out_degen_reg;

    logic                in_acc;
    logic [2:0]          pair;
    logic                second;
    logic [1:0]          kk;
    logic [D-1:0]        op_a, op_b;
    logic [AW-1:0]       nm_sel;
    logic [ACCW-1:0]     add_val;
    logic [ACCW-1:0]     acc_step;
    logic                mul_last;
    logic [AW-1:0]       vsrc [3];
    logic [AW-1:0]       vmag [3];
    logic                vzero;
    logic [AW-1:0]       or_all;
    logic                too_wide, too_narrow;
    logic [SQ_W-1:0]     sq_tmp;
    logic                sq_ge;
    logic [SQ_W-1:0]     root_next;
    logic                div_ge;
    logic [Q_W-1:0]      q_next;
    logic                res_neg;
    logic [RES_W-1:0]    res_val;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        pair   = term_reg[3:1];
        second = term_reg[0];
        kk     = 2'd0;
        op_a   = second ? du2_reg : du1_reg;
        op_b   = second ? dv1_reg : dv2_reg;
        if (pair != 3'd0 && pair < 3'd4)
        begin
            kk   = 2'(pair - 3'd1);
            op_a = second ? dv1_reg : dv2_reg;
            op_b = second ? e2_reg[kk] : e1_reg[kk];
        end
        else if (pair >= 3'd4)
        begin
            kk   = 2'(pair - 3'd4);
            op_a = second ? du2_reg : du1_reg;
            op_b = second ? e1_reg[kk] : e2_reg[kk];
        end
    end

    assign nm_sel   = nm_reg[(state_reg == ST_SQ) ? term_reg[1:0] : comp_reg];
    assign add_val  = mplier_reg[0] ? mcand_reg : '0;
    assign acc_step = mneg_reg ? (acc_reg - add_val) : (acc_reg + add_val);
    assign mul_last = (mplier_reg[BW-1:1] == '0);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vsrc[k] = vsel_reg ? bt_reg[k] : tan_reg[k];
            vmag[k] = vsrc[k][AW-1] ? (~vsrc[k] + AW'(1)) : vsrc[k];
        end
    end

    assign vzero      = (vmag[0] == '0) && (vmag[1] == '0) && (vmag[2] == '0);
    assign or_all     = nm_reg[0] | nm_reg[1] | nm_reg[2];
    assign too_wide   = |or_all[AW-1:NORM_BITS];
    assign too_narrow = !or_all[NORM_BITS-1];

    assign sq_tmp    = root_reg + bit_reg;
    assign sq_ge     = (acc_reg >= ACCW'(sq_tmp));
    assign root_next = sq_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

    assign div_ge  = (acc_reg >= ACCW'(den_reg));
    assign q_next  = {q_reg[Q_W-2:0], div_ge};
    assign res_neg = nneg_reg[comp_reg] ^ (mirror_reg && comp_reg != 2'd1);
    assign res_val = res_neg ? (RES_W'(0) - RES_W'(q_next)) : RES_W'(q_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            mirror_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            mul_busy_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mirror_reg <= cfg_wr_data;
            end
            // In ST_DONE the output register is handled by that state alone.
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (cnt_reg != 2'd2)
                        begin
                            if (cnt_reg[0])
                            begin
                                pos_reg[3] <= pos_x;
                                pos_reg[4] <= pos_y;
                                pos_reg[5] <= pos_z;
                                tex_reg[2] <= tex_u;
                                tex_reg[3] <= tex_v;
                            end
                            else
                            begin
                                pos_reg[0] <= pos_x;
                                pos_reg[1] <= pos_y;
                                pos_reg[2] <= pos_z;
                                tex_reg[0] <= tex_u;
                                tex_reg[1] <= tex_v;
                            end
                            cnt_reg <= end_of_mesh ? 2'd0 : cnt_reg + 2'd1;
                        end
                        else
                        begin
                            du1_reg   <= sx(tex_reg[2]) - sx(tex_reg[0]);
                            dv1_reg   <= sx(tex_reg[3]) - sx(tex_reg[1]);
                            du2_reg   <= sx(tex_u) - sx(tex_reg[0]);
                            dv2_reg   <= sx(tex_v) - sx(tex_reg[1]);
                            e1_reg[0] <= sx(pos_reg[3]) - sx(pos_reg[0]);
                            e1_reg[1] <= sx(pos_reg[4]) - sx(pos_reg[1]);
                            e1_reg[2] <= sx(pos_reg[5]) - sx(pos_reg[2]);
                            e2_reg[0] <= sx(pos_x) - sx(pos_reg[0]);
                            e2_reg[1] <= sx(pos_y) - sx(pos_reg[1]);
                            e2_reg[2] <= sx(pos_z) - sx(pos_reg[2]);
                            cnt_reg      <= 2'd0;
                            term_reg     <= 4'd0;
                            mul_busy_reg <= 1'b0;
                            degen_reg    <= 1'b0;
                            vsel_reg     <= 1'b0;
                            state_reg    <= ST_MUL;
                        end
                    end
                end

                ST_MUL:
                begin
                    if (!mul_busy_reg)
                    begin
                        mcand_reg    <= ACCW'(mag_d(op_a));
                        mplier_reg   <= BW'(mag_d(op_b));
                        mneg_reg     <= op_a[D-1] ^ op_b[D-1] ^ second;
                        mul_busy_reg <= 1'b1;
                        if (!second)
                        begin
                            acc_reg <= '0;
                        end
                    end
                    else
                    begin
                        acc_reg    <= acc_step;
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                        if (mul_last)
                        begin
                            mul_busy_reg <= 1'b0;
                            term_reg     <= term_reg + 4'd1;
                            if (second)
                            begin
                                if (pair == 3'd0)
                                begin
                                    det_reg <= acc_step[AW-1:0];
                                end
                                else if (pair < 3'd4)
                                begin
                                    tan_reg[kk] <= acc_step[AW-1:0];
                                end
                                else
                                begin
                                    bt_reg[kk] <= acc_step[AW-1:0];
                                end
                            end
                            if (term_reg == LAST_TERM)
                            begin
                                if (det_reg == '0)
                                begin
                                    degen_reg <= 1'b1;
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    state_reg <= ST_NLOAD;
                                end
                            end
                        end
                    end
                end

                ST_NLOAD:
                begin
                    if (vzero)
                    begin
                        degen_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            nm_reg[k]   <= vmag[k];
                            nneg_reg[k] <= vsrc[k][AW-1] ^ det_reg[AW-1];
                        end
                        state_reg <= ST_NSHIFT;
                    end
                end

                ST_NSHIFT:
                begin
                    // Bring the largest magnitude to exactly NORM_BITS bits.
                    if (too_wide)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            nm_reg[k] <= nm_reg[k] >> 1;
                        end
                    end
                    else if (too_narrow)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            nm_reg[k] <= nm_reg[k] << 1;
                        end
                    end
                    else
                    begin
                        acc_reg      <= '0;
                        term_reg     <= 4'd0;
                        mul_busy_reg <= 1'b0;
                        state_reg    <= ST_SQ;
                    end
                end

                ST_SQ:
                begin
                    if (!mul_busy_reg)
                    begin
                        mcand_reg    <= ACCW'(nm_sel[NORM_BITS-1:0]);
                        mplier_reg   <= BW'(nm_sel[NORM_BITS-1:0]);
                        mneg_reg     <= 1'b0;
                        mul_busy_reg <= 1'b1;
                    end
                    else
                    begin
                        acc_reg    <= acc_step;
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                        if (mul_last)
                        begin
                            mul_busy_reg <= 1'b0;
                            term_reg     <= term_reg + 4'd1;
                            if (term_reg == LAST_SQ)
                            begin
                                root_reg  <= '0;
                                bit_reg   <= SQ_W'(1) << (SQ_W - 2);
                                state_reg <= ST_SQRT;
                            end
                        end
                    end
                end

                ST_SQRT:
                begin
                    if (sq_ge)
                    begin
                        acc_reg <= acc_reg - ACCW'(sq_tmp);
                    end
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        len_reg   <= root_next[LEN_W-1:0];
                        comp_reg  <= 2'd0;
                        state_reg <= ST_DLOAD;
                    end
                end

                ST_DLOAD:
                begin
                    // Rounded quotient: add half the length before dividing.
                    acc_reg   <= ACCW'({nm_sel[NORM_BITS-1:0], UNIT_SHIFT'(0)})
                               + ACCW'(len_reg >> 1);
                    den_reg   <= {len_reg, UNIT_SHIFT'(0)};
                    q_reg     <= '0;
                    dcnt_reg  <= 4'd0;
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (div_ge)
                    begin
                        acc_reg <= acc_reg - ACCW'(den_reg);
                    end
                    den_reg  <= den_reg >> 1;
                    q_reg    <= q_next;
                    dcnt_reg <= dcnt_reg + 4'd1;
                    if (dcnt_reg == LAST_DIV)
                    begin
                        if (vsel_reg)
                        begin
                            rb_reg[comp_reg] <= res_val;
                        end
                        else
                        begin
                            rt_reg[comp_reg] <= res_val;
                        end
                        if (comp_reg == 2'd2)
                        begin
                            if (vsel_reg)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                vsel_reg  <= 1'b1;
                                state_reg <= ST_NLOAD;
                            end
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= ST_DLOAD;
                        end
                    end
                end

                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            out_t_reg[k] <= degen_reg ? '0 : rt_reg[k];
                            out_b_reg[k] <= degen_reg ? '0 : rb_reg[k];
                        end
                        out_degen_reg <= degen_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign tangent_x   = out_t_reg[0];
    assign tangent_y   = out_t_reg[1];
    assign tangent_z   = out_t_reg[2];
    assign bitangent_x = out_b_reg[0];
    assign bitangent_y = out_b_reg[1];
    assign bitangent_z = out_b_reg[2];
    assign degenerate  = out_degen_reg;

endmodule
`default_nettype wire

[rtl/core/tts_checker.sv]
// Port-level checks for the tangent-space block, bound to its top level.
`default_nettype none
`include "triangle_tangent_space_macros.svh"
module tts_checker #(
    parameter int COORD_WIDTH = 32
) (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 cfg_wr_en,
    input wire                                 cfg_wr_data,
    input wire                                 in_valid,
    input wire                                 in_stall,
    input wire signed [COORD_WIDTH-1:0]        pos_x,
    input wire signed [COORD_WIDTH-1:0]        pos_y,
    input wire signed [COORD_WIDTH-1:0]        pos_z,
    input wire signed [COORD_WIDTH-1:0]        tex_u,
    input wire signed [COORD_WIDTH-1:0]        tex_v,
    input wire                                 end_of_mesh,
    input wire                                 out_valid,
    input wire                                 out_stall,
    input wire signed [tts_pkg::RES_W-1:0]     tangent_x,
    input wire signed [tts_pkg::RES_W-1:0]     tangent_y,
    input wire signed [tts_pkg::RES_W-1:0]     tangent_z,
    input wire signed [tts_pkg::RES_W-1:0]     bitangent_x,
    input wire signed [tts_pkg::RES_W-1:0]     bitangent_y,
    input wire signed [tts_pkg::RES_W-1:0]     bitangent_z,
    input wire                                 degenerate
);
    import tts_pkg::*;

    logic signed [RES_W-1:0] one_q;
    assign one_q = RES_W'(UNIT_ONE);

    // A stalled result stays offered.
    `TTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // A stalled result keeps its vector.
    `TTS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(tangent_x) && $stable(tangent_y) && $stable(tangent_z) && $stable(bitangent_x) && $stable(bitangent_y) && $stable(bitangent_z) && $stable(degenerate))

    // A degenerate triangle reports all-zero vectors.
    `TTS_ASSERT_IMPL(a_degen_zero, clk, rst_n, out_valid && degenerate, tangent_x == 0 && tangent_y == 0 && tangent_z == 0 && bitangent_x == 0 && bitangent_y == 0 && bitangent_z == 0)

    // Unit vector components, all but bitangent_y, never exceed one in magnitude.
    `TTS_ASSERT_IMPL(a_unit_range, clk, rst_n, out_valid, tangent_x <= one_q && tangent_x >= -one_q && tangent_y <= one_q && tangent_y >= -one_q && tangent_z <= one_q && tangent_z >= -one_q && bitangent_x <= one_q && bitangent_x >= -one_q && bitangent_z <= one_q && bitangent_z >= -one_q)

endmodule

bind triangle_tangent_space tts_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tts_checker (.*);
`default_nettype wire

[bench/tts_checker.sv]
// Checker for the tangent-space block: watches both channels, predicts and compares.
module tts_scoreboard (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cfg_wr_en,
    input  wire               cfg_wr_data,
    input  wire               in_valid,
    input  wire               in_stall,
    input  wire signed [31:0] pos_x,
    input  wire signed [31:0] pos_y,
    input  wire signed [31:0] pos_z,
    input  wire signed [31:0] tex_u,
    input  wire signed [31:0] tex_v,
    input  wire               end_of_mesh,
    input  wire               out_valid,
    input  wire               out_stall,
    input  wire signed [15:0] tangent_x,
    input  wire signed [15:0] tangent_y,
    input  wire signed [15:0] tangent_z,
    input  wire signed [15:0] bitangent_x,
    input  wire signed [15:0] bitangent_y,
    input  wire signed [15:0] bitangent_z,
    input  wire               degenerate,
    output int                fails,
    output int                outstanding
);
    typedef logic signed [127:0] wide_t;
    typedef struct packed {
        logic [15:0] tx, ty, tz, bx, by, bz;
        logic        degen;
    } frame_t;

    frame_t             frames_due[$];
    logic               mirror;
    int                 corners_held;
    logic signed [31:0] held_pos[2][3];
    logic signed [31:0] held_uv[2][2];
    int                 fail_count;

    assign fails = fail_count;
    assign outstanding = frames_due.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w >>= 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end
            else
                res >>= 1;
            bit_w >>= 2;
        end
        return res;
    endfunction

    // Scales a vector to unit length in Q2.14; returns 0 for a zero vector.
    function automatic bit unit_length(input wide_t cx, cy, cz, input bit flip,
                                       output logic [15:0] ox, oy, oz);
        wide_t           comp[3];
        wide_t           mag[3];
        bit              neg[3];
        longint unsigned m[3];
        longint unsigned len, q, sum;
        int              maxbl, bl;
        comp[0] = cx;
        comp[1] = cy;
        comp[2] = cz;
        maxbl = 0;
        for (int k = 0; k < 3; k++)
        begin
            neg[k] = (comp[k] < 0) != flip;
            mag[k] = comp[k] < 0 ? -comp[k] : comp[k];
            bl = 0;
            for (int i = 0; i < 128; i++)
                if (mag[k][i])
                    bl = i + 1;
            if (bl > maxbl)
                maxbl = bl;
        end
        if (maxbl == 0)
            return 0;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            if (maxbl > 30)
                m[k] = 64'(mag[k] >> (maxbl - 30));
            else
                m[k] = 64'(mag[k] << (30 - maxbl));
            sum += m[k] * m[k];
        end
        len = int_sqrt(sum);
        for (int k = 0; k < 3; k++)
        begin
            q = (m[k] * 16384 + len / 2) / len;
            if (neg[k])
                q = -q;
            case (k)
                0: ox = q[15:0];
                1: oy = q[15:0];
                default: oz = q[15:0];
            endcase
        end
        return 1;
    endfunction

    function automatic frame_t predict_frame(input logic signed [31:0] px, py, pz, u, v);
        frame_t f;
        wide_t  du1, dv1, du2, dv2, det;
        wide_t  e1[3], e2[3], tc[3], bc[3];
        logic signed [31:0] pin[3];
        bit     flip, ok;
        pin[0] = px;
        pin[1] = py;
        pin[2] = pz;
        du1 = wide_t'(held_uv[1][0]) - wide_t'(held_uv[0][0]);
        dv1 = wide_t'(held_uv[1][1]) - wide_t'(held_uv[0][1]);
        du2 = wide_t'(u) - wide_t'(held_uv[0][0]);
        dv2 = wide_t'(v) - wide_t'(held_uv[0][1]);
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = wide_t'(held_pos[1][k]) - wide_t'(held_pos[0][k]);
            e2[k] = wide_t'(pin[k]) - wide_t'(held_pos[0][k]);
            tc[k] = dv2 * e1[k] - dv1 * e2[k];
            bc[k] = du1 * e2[k] - du2 * e1[k];
        end
        det = du1 * dv2 - du2 * dv1;
        flip = det < 0;
        f = '0;
        ok = det != 0;
        if (ok)
            ok = unit_length(tc[0], tc[1], tc[2], flip, f.tx, f.ty, f.tz);
        if (ok)
            ok = unit_length(bc[0], bc[1], bc[2], flip, f.bx, f.by, f.bz);
        if (!ok)
            f = '0;
        else if (mirror)
        begin
            f.tx = -f.tx;
            f.tz = -f.tz;
            f.bx = -f.bx;
            f.bz = -f.bz;
        end
        f.degen = !ok;
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            mirror <= 1'b0;
            corners_held = 0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (frames_due.size() == 0)
                    report("unexpected result", tangent_x, 0);
                else
                begin
                    want = frames_due.pop_front();
                    if (tangent_x !== want.tx)
                        report("tangent_x", tangent_x, $signed(want.tx));
                    if (tangent_y !== want.ty)
                        report("tangent_y", tangent_y, $signed(want.ty));
                    if (tangent_z !== want.tz)
                        report("tangent_z", tangent_z, $signed(want.tz));
                    if (bitangent_x !== want.bx)
                        report("bitangent_x", bitangent_x, $signed(want.bx));
                    if (bitangent_y !== want.by)
                        report("bitangent_y", bitangent_y, $signed(want.by));
                    if (bitangent_z !== want.bz)
                        report("bitangent_z", bitangent_z, $signed(want.bz));
                    if (degenerate !== want.degen)
                        report("degenerate", degenerate, want.degen);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (corners_held < 2)
                begin
                    held_pos[corners_held] = '{pos_x, pos_y, pos_z};
                    held_uv[corners_held] = '{tex_u, tex_v};
                    corners_held++;
                end
                else
                begin
                    frames_due = {frames_due,
                                  predict_frame(pos_x, pos_y, pos_z, tex_u, tex_v)};
                    corners_held = 0;
                end
                if (end_of_mesh)
                    corners_held = 0;
            end
            if (cfg_wr_en)
                mirror <= cfg_wr_data;
        end
    end
endmodule

[bench/tb.sv]
// Testbench top: drives corner requests and mode writes, and gives the verdict.
module tb;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [31:0] MAXV = 32'h7fffffff;
    localparam logic [31:0] MINV = 32'h80000000;
    localparam logic [31:0] ONE = 32'h00010000;

    logic        clk, rst_n, cfg_wr_en, cfg_wr_data, in_valid, end_of_mesh, out_stall;
    logic signed [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
    wire         in_stall, out_valid, degenerate;
    wire signed [15:0] tangent_x, tangent_y, tangent_z;
    wire signed [15:0] bitangent_x, bitangent_y, bitangent_z;
    int          fails, outstanding, cycles;

    triangle_tangent_space #(.COORD_WIDTH(32)) dut (.*);
    tts_scoreboard chk (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("FAIL triangle_tangent_space");
                $finish;
            end
        end
    end

    // Result side: stall for a random stretch before each result.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            out_stall = n > 0;
            repeat (n) @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_corner(input logic [31:0] px, py, pz, u, v, input bit eom);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pos_x = px;
        pos_y = py;
        pos_z = pz;
        tex_u = u;
        tex_v = v;
        end_of_mesh = eom;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_mirror(input bit value);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(input int span);
        case (span)
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            2: return $signed($urandom_range(0, 128)) - 64;
            default: return $urandom_range(0, 1) ? MAXV : MINV;
        endcase
    endfunction

    task automatic random_triangle();
        int span, cut;
        logic [31:0] u0, v0;
        span = $urandom_range(0, 9);
        span = span < 3 ? 0 : span < 7 ? 1 : span < 9 ? 2 : 3;
        // Occasionally break the triangle off early, or reuse one texture coordinate.
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
        u0 = rand_coord(span);
        v0 = rand_coord(span);
        for (int c = 1; c <= 3; c++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_corner(rand_coord(span), rand_coord(span), rand_coord(span), u0, v0,
                            c == cut || (c == 3 && $urandom_range(0, 1)));
            else
                send_corner(rand_coord(span), rand_coord(span), rand_coord(span),
                            rand_coord(span), rand_coord(span),
                            c == cut || (c == 3 && $urandom_range(0, 1)));
            if (c == cut)
                break;
        end
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            random_triangle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        in_valid = 1'b0;
        end_of_mesh = 1'b0;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        tex_u = 0;
        tex_v = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        write_mirror(1'b0);

        // Right-angle unit triangle.
        send_corner(0, 0, 0, 0, 0, 0);
        send_corner(ONE, 0, 0, ONE, 0, 0);
        send_corner(0, ONE, 0, 0, ONE, 0);
        // Field extremes.
        send_corner(MINV, MAXV, MINV, MINV, MAXV, 0);
        send_corner(MAXV, MINV, MAXV, MAXV, MINV, 0);
        send_corner(MINV, MINV, MAXV, MAXV, MAXV, 0);
        // Zero determinant: every corner has the same texture coordinate.
        send_corner(0, 0, 0, ONE, ONE, 0);
        send_corner(ONE, 0, ONE, ONE, ONE, 0);
        send_corner(0, ONE, 0, ONE, ONE, 0);
        // Zero vectors: all corners at one position.
        send_corner(ONE, ONE, ONE, 0, 0, 0);
        send_corner(ONE, ONE, ONE, ONE, 0, 0);
        send_corner(ONE, ONE, ONE, 0, ONE, 0);
        // End of mesh on the first corner, then on the second.
        send_corner(MAXV, MAXV, MAXV, MAXV, MAXV, 1);
        send_corner(MINV, MINV, MINV, MINV, MINV, 0);
        send_corner(MAXV, 0, MINV, 0, MAXV, 1);
        // Negative determinant, with end of mesh on the completing corner.
        send_corner(0, 0, 0, 0, 0, 0);
        send_corner(ONE, 0, 0, 0, ONE, 0);
        send_corner(0, ONE, ONE, ONE, 0, 1);

        write_mirror(1'b1);
        send_corner(0, 0, 0, 0, 0, 0);
        send_corner(ONE, 0, ONE, ONE, 0, 0);
        send_corner(0, ONE, ONE, 0, ONE, 0);
        random_phase(100);

        // Let every outstanding result drain before continuing.
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        random_phase(50);

        write_mirror(1'b0);
        random_phase(100);
        write_mirror(1'b1);
        random_phase(60);

        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (1000) @(negedge clk);
        if (fails == 0)
            $display("PASS triangle_tangent_space");
        else
            $display("FAIL triangle_tangent_space");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/tts_pkg.sv
rtl/core/triangle_tangent_space.sv
rtl/core/tts_checker.sv
bench/tts_checker.sv
bench/tb.sv
